[rtl/isl_pkg.sv]
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and constants for the indexed shift list.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = 4;
    localparam int CNT_OUT_W    = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] index;
        t_word            value;
    } t_in_item;

    typedef struct packed {
        t_word                read_value;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_empty;
        logic [1:0]           status;
    } t_out_item;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             ers;
        logic [IDX_W-1:0] idx;
        t_word            value;
    } t_shift_cmd;

endpackage

[rtl/isl_cell.sv]
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: loads the new word, takes its lower or upper neighbor's word
// on an insert or erase, otherwise holds.
// ----------------------------------------------------------------------------
module isl_cell #(
    parameter int POS = 0
) (
    input  logic               i_clk,
    input  isl_pkg::t_shift_cmd i_cmd,
    input  isl_pkg::t_word     i_lower,
    input  isl_pkg::t_word     i_upper,
    output isl_pkg::t_word     o_word
);
    import isl_pkg::*;

    t_word r_word;
    t_word n_word;
    logic  above;
    logic  at_idx;

    assign above  = POS > int'(i_cmd.idx);
    assign at_idx = POS == int'(i_cmd.idx);

    always_comb begin
        n_word = r_word;
        if (i_cmd.ins) begin
            if (above) begin
                n_word = i_lower;
            end else if (at_idx) begin
                n_word = i_cmd.value;
            end
        end else if (i_cmd.ers) begin
            if (above || at_idx) begin
                n_word = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[rtl/indexed_shift_list.sv]
// ----------------------------------------------------------------------------
// indexed_shift_list
// Ordered list of signed words with read, insert, erase and clear at an index.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_item and raise i_start; the item is taken at
//   any clock edge where i_start is high and o_busy is low. o_busy stays low,
//   so a new item may be issued every cycle.
//   Result channel: o_valid pulses for one cycle, in the cycle after the item is
//   taken, with o_item holding read_value, count, is_empty and status.
//   Throughput is 1 item per cycle: every slot is a cell in a chain that
//   loads from its neighbor in the same cycle, so an insert or erase moves
//   the whole tail at once.
//   A rejected item (bad index, or insert into a full list) reports a status
//   code and leaves the list untouched. Reads return zero unless ok.
//   Reset (i_rst_n low, synchronous) empties the list and drops o_valid;
//   stored words are not cleared, they are unreachable until rewritten.
//   The receiver has no stall: a result not taken in its cycle is gone.
// ----------------------------------------------------------------------------
module indexed_shift_list #(
    parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  isl_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_valid,
    output isl_pkg::t_out_item o_item
);
    import isl_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int CNTO_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam int RD_N   = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    t_word      w_cell [CAPACITY];
    t_shift_cmd cmd;
    logic       accept;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic       full;
    t_word      rd_word;
    t_status    status;
    logic [CNTO_W-1:0] cnt_wide;

    assign accept  = i_start && !o_busy;
    assign idx_ext = CMP_W'(i_item.index);
    assign cnt_ext = CMP_W'(r_count);
    assign full    = r_count == CNT_W'(CAPACITY);

    // Only the first 2^IDX_W slots are reachable by a read.
    always_comb begin
        rd_word = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (int'(i_item.index) == k) begin
                rd_word = w_cell[k];
            end
        end
    end

    always_comb begin
        status  = ST_OK;
        n_count = r_count;
        cmd.ins = 1'b0;
        cmd.ers = 1'b0;
        cmd.idx = i_item.index;
        cmd.value = i_item.value;
        n_out.read_value = '0;
        case (i_item.op)
            OP_READ: begin
                if (idx_ext < cnt_ext) begin
                    n_out.read_value = rd_word;
                end else begin
                    status = ST_RANGE;
                end
            end
            OP_INSERT: begin
                if (idx_ext > cnt_ext) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.ins = accept;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_ERASE: begin
                if (idx_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    cmd.ers = accept;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
        cnt_wide       = CNTO_W'(n_count);
        n_out.count    = cnt_wide[CNT_OUT_W-1:0];
        n_out.is_empty = n_count == '0;
        n_out.status   = status;
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_word lower;
        t_word upper;
        if (k == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = w_cell[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign upper = w_cell[k];
        end else begin : g_mid_hi
            assign upper = w_cell[k+1];
        end
        isl_cell #(
            .POS (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_lower (lower),
            .i_upper (upper),
            .o_word  (w_cell[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_valid;
    assign o_item  = r_out;

`ifndef SYNTH
    a_valid_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept))
        else $error("result strobe without an accepted item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (status != ST_OK) |=> $stable(r_count))
        else $error("rejected item changed the count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.op == OP_CLEAR) |=> (r_count == '0) && o_item.is_empty)
        else $error("clear did not empty the list");
`endif

endmodule

[dv/indexed_shift_list_tb.sv]
// ----------------------------------------------------------------------------
// indexed_shift_list_tb
// Drives read, insert, erase and clear items into the indexed shift list,
// tracks the list contents in a shadow copy and checks every result word.
// A short directed opening covers empty-list and bad-index cases; random
// bursts then grow, drain and churn the list so that the full case is hit.
// ----------------------------------------------------------------------------
module indexed_shift_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isl_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;

    // Shadow of the list: predicts each result and checks it on arrival.
    class shift_list_sb;
        t_word     words [LIST_CAP];
        int        entry_count;
        t_out_item due_results [$];
        int        errors;
        int        op_seen [4];
        int        st_seen [3];
        int        results_seen;
        int        peak;

        function void apply_item(t_in_item it);
            t_out_item r;
            t_op       op;
            int        idx;
            r   = '0;
            op  = t_op'(it.op);
            idx = int'(it.index);
            r.status = ST_OK;
            case (op)
                OP_READ: begin
                    if (idx < entry_count) r.read_value = words[idx];
                    else r.status = ST_RANGE;
                end
                OP_INSERT: begin
                    if (idx > entry_count) begin
                        r.status = ST_RANGE;
                    end else if (entry_count >= LIST_CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int k = entry_count; k > idx; k--) words[k] = words[k-1];
                        words[idx] = it.value;
                        entry_count++;
                    end
                end
                OP_ERASE: begin
                    if (idx >= entry_count) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (int k = idx + 1; k < entry_count; k++) words[k-1] = words[k];
                        entry_count--;
                    end
                end
                default: entry_count = 0;
            endcase
            r.count    = entry_count[CNT_OUT_W-1:0];
            r.is_empty = (entry_count == 0);
            op_seen[op]++;
            st_seen[r.status]++;
            if (entry_count > peak) peak = entry_count;
            due_results.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing pending, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            field_check("read_value", want.read_value, got.read_value);
            field_check("count", 32'(want.count), 32'(got.count));
            field_check("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            field_check("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_valid;
    t_out_item o_item;

    shift_list_sb sb = new();
    int taken = 0;

    indexed_shift_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Results are checked before the item taken at the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_item);
            if (i_start && !o_busy) begin
                sb.apply_item(i_item);
                taken <= taken + 1;
            end
        end
    end

    function automatic t_in_item make_item(t_op op, int idx, logic [31:0] val);
        t_in_item it;
        it.op    = op;
        it.index = idx[IDX_W-1:0];
        it.value = val;
        return it;
    endfunction

    // Called just after a falling edge; returns at the falling edge after the
    // item has been taken.
    task automatic send_item(t_in_item it, int idle_pct);
        int          n;
        logic [63:0] junk;
        while ($urandom_range(99) < idle_pct) begin
            junk = {$urandom, $urandom};
            i_start <= 1'b0;
            i_item  <= junk[$bits(t_in_item)-1:0];
            @(negedge i_clk);
        end
        i_item  <= it;
        i_start <= 1'b1;
        n = taken;
        do @(negedge i_clk); while (taken == n);
    endtask

    // mode 0 grows the list, 1 drains it, 2 churns it
    function automatic t_in_item pick_item(int mode);
        int          roll;
        int          cnt;
        int          idx;
        t_op         op;
        logic [31:0] val;
        roll = $urandom_range(99);
        cnt  = sb.entry_count;
        if (roll < 2) op = OP_CLEAR;
        else if (roll < (mode == 0 ? 62 : mode == 1 ? 22 : 40)) op = OP_INSERT;
        else if (roll < (mode == 0 ? 82 : mode == 1 ? 50 : 70)) op = OP_READ;
        else op = OP_ERASE;
        if ($urandom_range(99) < 85) begin
            if (op == OP_INSERT) idx = $urandom_range(cnt > 15 ? 15 : cnt);
            else idx = (cnt == 0) ? 0 : $urandom_range(cnt - 1);
        end else begin
            idx = $urandom_range(15);
        end
        case ($urandom_range(39))
            0:       val = 32'h7fff_ffff;
            1:       val = 32'h8000_0000;
            2:       val = 32'h0000_0000;
            3:       val = 32'hffff_ffff;
            default: val = $urandom;
        endcase
        return make_item(op, idx, val);
    endfunction

    task automatic run_random(int n, int idle_pct);
        int done;
        int burst;
        int mode;
        done = 0;
        while (done < n) begin
            burst = $urandom_range(4, 40);
            mode  = $urandom_range(2);
            for (int j = 0; j < burst && done < n; j++) begin
                send_item(pick_item(mode), idle_pct);
                done++;
            end
        end
    endtask

    initial begin
        int spin;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list: every indexed op is out of range, clear still ok
        send_item(make_item(OP_READ,   0, 32'h1234_5678), 20);
        send_item(make_item(OP_ERASE,  0, 32'hdead_beef), 20);
        send_item(make_item(OP_INSERT, 1, 32'h0000_0001), 20);
        send_item(make_item(OP_CLEAR, 15, 32'hffff_ffff), 20);
        // build [min, 0, max, -1] through front, end and middle inserts
        send_item(make_item(OP_INSERT, 0, 32'h7fff_ffff), 20);
        send_item(make_item(OP_INSERT, 0, 32'h8000_0000), 20);
        send_item(make_item(OP_INSERT, 2, 32'hffff_ffff), 20);
        send_item(make_item(OP_INSERT, 1, 32'h0000_0000), 20);
        send_item(make_item(OP_INSERT, 5, 32'h5555_5555), 20);
        for (int k = 0; k < 5; k++) send_item(make_item(OP_READ, k, 32'hffff_ffff), 20);
        send_item(make_item(OP_READ,  15, 32'h0), 20);
        send_item(make_item(OP_ERASE,  3, 32'h0), 20);
        send_item(make_item(OP_ERASE,  0, 32'h0), 20);
        send_item(make_item(OP_ERASE,  2, 32'h0), 20);
        send_item(make_item(OP_READ,   1, 32'h0), 20);
        send_item(make_item(OP_CLEAR,  0, 32'h0), 20);
        send_item(make_item(OP_READ,   0, 32'h0), 20);

        run_random(480, 38);
        run_random(480, 69);
        run_random(490, 0);
        i_start <= 1'b0;

        spin = 0;
        while (sb.due_results.size() != 0 && spin < 100) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.due_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.due_results.size());
            sb.errors++;
        end

        $display("%0d items taken (%0d read, %0d insert, %0d erase, %0d clear), %0d results",
                 taken, sb.op_seen[OP_READ], sb.op_seen[OP_INSERT],
                 sb.op_seen[OP_ERASE], sb.op_seen[OP_CLEAR], sb.results_seen);
        $display("status ok/range/full %0d/%0d/%0d, list peaked at %0d of %0d entries",
                 sb.st_seen[ST_OK], sb.st_seen[ST_RANGE], sb.st_seen[ST_FULL],
                 sb.peak, LIST_CAP);
        if (sb.errors == 0) begin
            $display("PASS indexed_shift_list");
        end else begin
            $display("FAIL indexed_shift_list");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout");
        $display("FAIL indexed_shift_list");
        $finish;
    end

endmodule
